/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks clocked on clk with reset arst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define SFC_ASSERT_NEVER(lbl, cond, msg) \
	`SFC_ASSERT(lbl, !(cond), msg)

`endif

/* design/sfc_pkg.sv */
// ---------------------------------------------------------------------------
// sfc_pkg
// shared types and constants of the sphere frustum cull block
// ---------------------------------------------------------------------------
package sfc_pkg;

	localparam int PLANE_COUNT_DEF = 6;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FIELD_WIDTH     = 32;
	localparam int INDEX_WIDTH     = 3;
	localparam int FRAC_BITS       = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int S_TDATA_WIDTH   = 136;
	localparam int M_TDATA_WIDTH   = 8;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TEST = 1'b1
	} action_t;

	typedef struct packed {
		action_t                  action;
		logic [INDEX_WIDTH-1:0]   plane_index;
		logic [FIELD_WIDTH-1:0]   value_x;
		logic [FIELD_WIDTH-1:0]   value_y;
		logic [FIELD_WIDTH-1:0]   value_z;
		logic [FIELD_WIDTH-1:0]   value_w;
	} sfc_item_t;

endpackage

/* design/sfc_front.sv */
// ---------------------------------------------------------------------------
// sfc_front
// input register; classifies requests and drops loads to absent plane slots
// ---------------------------------------------------------------------------
module sfc_front import sfc_pkg::*; #(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sfc_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output sfc_item_t out_item
);

	logic      valid_s1;
	sfc_item_t item_s1;
	logic      keep;
	logic      accept;

	assign keep     = (in_item.action == ACT_TEST) || (int'(in_item.plane_index) < PLANE_COUNT);
	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

/* design/sfc_queue.sv */
// ---------------------------------------------------------------------------
// sfc_queue
// short request queue between front and back
// ---------------------------------------------------------------------------
module sfc_queue import sfc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  sfc_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output sfc_item_t pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sfc_item_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* design/sfc_back.sv */
// ---------------------------------------------------------------------------
// sfc_back
// plane store and the distance pipeline, product and sum stages with output register
// ---------------------------------------------------------------------------
module sfc_back import sfc_pkg::*; #(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sfc_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      visible
);

	localparam int VW = VALUE_WIDTH;
	localparam int PW = 2 * VW;
	localparam int DW = VW + 1;
	localparam int SW = 2 * VW + 2;
	localparam int TW = SW + 1;

	logic signed [VW-1:0] nx_q [PLANE_COUNT];
	logic signed [VW-1:0] ny_q [PLANE_COUNT];
	logic signed [VW-1:0] nz_q [PLANE_COUNT];
	logic signed [VW-1:0] d_q  [PLANE_COUNT];

	logic signed [PW-1:0] px_s1 [PLANE_COUNT];
	logic signed [PW-1:0] py_s1 [PLANE_COUNT];
	logic signed [PW-1:0] pz_s1 [PLANE_COUNT];
	logic signed [DW-1:0] dr_s1 [PLANE_COUNT];
	logic signed [SW-1:0] sa_s2 [PLANE_COUNT];
	logic signed [SW-1:0] sb_s2 [PLANE_COUNT];
	logic signed [TW-1:0] total [PLANE_COUNT];
	logic [PLANE_COUNT-1:0] cull;

	logic test_s1;
	logic test_s2;
	logic out_valid_q;
	logic visible_q;

	logic adv;
	logic pop;
	logic load;
	logic signed [VW-1:0] cx;
	logic signed [VW-1:0] cy;
	logic signed [VW-1:0] cz;
	logic signed [VW-1:0] cr;

	// whole pipeline moves together, stalls only on a held result
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign pop      = in_valid && adv;
	assign load     = pop && (in_item.action == ACT_LOAD);

	assign cx = $signed(in_item.value_x[VW-1:0]);
	assign cy = $signed(in_item.value_y[VW-1:0]);
	assign cz = $signed(in_item.value_z[VW-1:0]);
	assign cr = $signed(in_item.value_w[VW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				nx_q[i] <= '0;
				ny_q[i] <= '0;
				nz_q[i] <= '0;
				d_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				if (load && (int'(in_item.plane_index) == i)) begin
					nx_q[i] <= cx;
					ny_q[i] <= cy;
					nz_q[i] <= cz;
					d_q[i]  <= cr;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_s1     <= 1'b0;
			test_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			test_s1     <= pop && (in_item.action == ACT_TEST);
			test_s2     <= test_s1;
			out_valid_q <= test_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				px_s1[i] <= nx_q[i] * cx;
				py_s1[i] <= ny_q[i] * cy;
				pz_s1[i] <= nz_q[i] * cz;
				// offset plus radius, both raised to the product scale later
				dr_s1[i] <= DW'(d_q[i]) + DW'(cr);
				sa_s2[i] <= SW'(px_s1[i]) + SW'(py_s1[i]);
				sb_s2[i] <= SW'(pz_s1[i]) + (SW'(dr_s1[i]) <<< FRAC_BITS);
			end
			visible_q <= ~|cull;
		end
	end

	// exact sum of dist plus radius, culled when negative
	always_comb begin
		for (int i = 0; i < PLANE_COUNT; i++) begin
			total[i] = TW'(sa_s2[i]) + TW'(sb_s2[i]);
			cull[i]  = total[i][TW-1];
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

endmodule

/* design/sphere_frustum_cull.sv */
// ---------------------------------------------------------------------------
// sphere_frustum_cull
// sphere test against a store of clipping planes, loads and tests in one stream
// ---------------------------------------------------------------------------
//  channel  | dir | data                                  | side info
//  s_*      | in  | plane_index, value_x/y/z/w             | tuser: action
//  m_*      | out | visible                               | none
//
//  one request per cycle sustained while results are taken, loads and tests alike
//  a test result passes through the input register, queue, product stage,
//  sum stage and output register
//  arst_n clears the plane store to zero and empties queue and pipeline
//  a held result stalls the back pipeline; the queue lets the input run on
// ---------------------------------------------------------------------------
module sphere_frustum_cull import sfc_pkg::*; #(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// plane_index[2:0], value_x[34:3], value_y[66:35], value_z[98:67],
	// value_w[130:99], zero pad
	input  logic [S_TDATA_WIDTH-1:0] s_tdata,
	// action[0]
	input  logic [0:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// visible[0], zero pad
	output logic [M_TDATA_WIDTH-1:0] m_tdata
);

	sfc_item_t in_item;
	sfc_item_t front_item;
	sfc_item_t queue_item;
	logic      front_valid;
	logic      front_ready;
	logic      queue_valid;
	logic      queue_ready;
	logic      visible;

	always_comb begin
		in_item.action      = action_t'(s_tuser[0]);
		in_item.plane_index = s_tdata[2:0];
		in_item.value_x     = s_tdata[34:3];
		in_item.value_y     = s_tdata[66:35];
		in_item.value_z     = s_tdata[98:67];
		in_item.value_w     = s_tdata[130:99];
	end

	sfc_front #(
		.PLANE_COUNT (PLANE_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	sfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	sfc_back #(
		.PLANE_COUNT (PLANE_COUNT),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (queue_valid),
		.in_ready  (queue_ready),
		.in_item   (queue_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.visible   (visible)
	);

	assign m_tdata = {{(M_TDATA_WIDTH-1){1'b0}}, visible};

endmodule

/* design/sfc_checker.sv */
// ---------------------------------------------------------------------------
// sfc_checker
// port level checks of the sphere frustum cull block
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfc_checker import sfc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [0:0]               s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [M_TDATA_WIDTH-1:0] m_tdata
);

	logic [7:0] pend_q;
	logic       test_in;
	logic       res_out;

	assign test_in = s_tvalid && s_tready && (s_tuser[0] == ACT_TEST);
	assign res_out = m_tvalid && m_tready;

	// tests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (test_in && !res_out) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_out && !test_in) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`SFC_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")
	`SFC_ASSERT(a_out_stable, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")
	`SFC_ASSERT_NEVER(a_no_orphan, m_tvalid && (pend_q == 8'd0), "result without a pending test")
	`SFC_ASSERT_NEVER(a_pad_zero, m_tvalid && (m_tdata[M_TDATA_WIDTH-1:1] != '0), "pad bits set")

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (.*);

/* tb/tb_sphere_frustum_cull.sv */
// ---------------------------------------------------------------------------
// tb_sphere_frustum_cull
// streams plane loads and sphere tests into the cull block, predicts each
// visible flag from a local copy of the plane store with exact wide sums and
// checks every returned flag in order; random idling on both sides and one
// long output hold-off that backs up the input
// ---------------------------------------------------------------------------
module tb_sphere_frustum_cull import sfc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAIL_ITEMS   = 150;
	localparam int RANDOM_ITEMS = 1025;
	localparam int STUCK_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 20;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
	logic [0:0]               s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [M_TDATA_WIDTH-1:0] m_tdata;

	sphere_frustum_cull u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sfc_item_t pending_q[$];
	logic      visible_q[$];

	logic signed [FIELD_WIDTH-1:0] plane_nx[PLANE_COUNT_DEF];
	logic signed [FIELD_WIDTH-1:0] plane_ny[PLANE_COUNT_DEF];
	logic signed [FIELD_WIDTH-1:0] plane_nz[PLANE_COUNT_DEF];
	logic signed [FIELD_WIDTH-1:0] plane_d[PLANE_COUNT_DEF];

	int   mismatches = 0;
	int   results_seen = 0;
	int   stuck_cycles = 0;
	int   send_gap = 0;
	int   hold_left = 0;
	logic long_hold_done = 1'b0;
	logic quiet_tail = 1'b0;

	// every slot culls against the exact sum dist + r, kept in 80 signed bits
	function automatic logic sphere_visible(input logic signed [FIELD_WIDTH-1:0] cx, cy, cz, r);
		logic signed [79:0] reach;
		logic               seen;
		seen = 1'b1;
		for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
			reach = plane_nx[p] * cx + plane_ny[p] * cy + plane_nz[p] * cz
				+ (plane_d[p] <<< FRAC_BITS) + (r <<< FRAC_BITS);
			if (reach < 0)
				seen = 1'b0;
		end
		return seen;
	endfunction

	task automatic record_request(input sfc_item_t req);
		if (req.action == ACT_LOAD) begin
			// slots past the store are dropped
			if (req.plane_index < PLANE_COUNT_DEF) begin
				plane_nx[req.plane_index] = req.value_x;
				plane_ny[req.plane_index] = req.value_y;
				plane_nz[req.plane_index] = req.value_z;
				plane_d[req.plane_index]  = req.value_w;
			end
		end else begin
			visible_q.push_back(sphere_visible(req.value_x, req.value_y, req.value_z,
				req.value_w));
		end
	endtask

	task automatic queue_request(input action_t act, input int idx,
		input logic [FIELD_WIDTH-1:0] x, y, z, w);
		sfc_item_t req;
		req.action      = act;
		req.plane_index = idx[INDEX_WIDTH-1:0];
		req.value_x     = x;
		req.value_y     = y;
		req.value_z     = z;
		req.value_w     = w;
		pending_q.push_back(req);
	endtask

	// roughly -4.0 .. +4.0
	function automatic logic [FIELD_WIDTH-1:0] near_q16();
		return FIELD_WIDTH'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
	endfunction

	function automatic logic [FIELD_WIDTH-1:0] wild_q16();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 32'h8000_0000;
			2:       return 32'h7fff_ffff;
			3, 4:    return $urandom;
			default: return near_q16();
		endcase
	endfunction

	// request side
	always @(posedge clk) begin
		logic go;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				record_request(pending_q[0]);
				void'(pending_q.pop_front());
			end
			go = s_tvalid && !s_tready;
			if (!go) begin
				if (send_gap != 0)
					send_gap = send_gap - 1;
				else if (pending_q.size() != 0) begin
					if (pending_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(0, 15);
					else
						go = 1'b1;
				end
			end
			s_tvalid <= go;
			if (go) begin
				s_tdata <= S_TDATA_WIDTH'({pending_q[0].value_w, pending_q[0].value_z,
					pending_q[0].value_y, pending_q[0].value_x, pending_q[0].plane_index});
				s_tuser <= pending_q[0].action;
			end
			quiet_tail <= pending_q.size() <= TAIL_ITEMS;
		end
	end

	// result side stalls, with one long hold-off once results are flowing
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (!long_hold_done && results_seen >= 40) begin
				long_hold_done <= 1'b1;
				hold_left      <= LONG_HOLD - 1;
				m_tready       <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				hold_left <= $urandom_range(0, 15);
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		logic want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (visible_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with no test pending, visible %0b", $realtime,
						m_tdata[0]);
				mismatches = mismatches + 1;
			end else begin
				want = visible_q.pop_front();
				if (m_tdata[0] !== want) begin
					if (mismatches < 10)
						$display("%0t: visible expected %0b got %0b", $realtime, want,
							m_tdata[0]);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (pending_q.size() == 0 && visible_q.size() == 0))
			stuck_cycles <= 0;
		else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("sphere_frustum_cull: mismatch");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		int n;
		int tests;
		for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
			plane_nx[p] = '0;
			plane_ny[p] = '0;
			plane_nz[p] = '0;
			plane_d[p]  = '0;
		end

		// cleared store: only a negative radius culls
		queue_request(ACT_TEST, 0, 0, 0, 0, 0);
		queue_request(ACT_TEST, 3, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'hffff_ffff);
		queue_request(ACT_TEST, 7, 0, 0, 0, 32'h8000_0000);
		queue_request(ACT_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		// loads past the last slot leave the store alone
		queue_request(ACT_LOAD, 6, 32'h0001_0000, 0, 0, 32'h8000_0000);
		queue_request(ACT_LOAD, 7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
		queue_request(ACT_TEST, 0, 0, 0, 0, 0);
		// plane x >= 0 in slot 0, radius 1.0: touching is visible
		queue_request(ACT_LOAD, 0, 32'h0001_0000, 0, 0, 0);
		queue_request(ACT_TEST, 0, 32'hfffe_0000, 0, 0, 32'h0001_0000);
		queue_request(ACT_TEST, 0, 32'hffff_0000, 0, 0, 32'h0001_0000);
		queue_request(ACT_TEST, 0, 32'hfffe_ffff, 0, 0, 32'h0001_0000);
		// extreme plane in the last slot
		queue_request(ACT_LOAD, 5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		queue_request(ACT_TEST, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		queue_request(ACT_TEST, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		queue_request(ACT_TEST, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		queue_request(ACT_TEST, 1, 0, 0, 0, 32'h8000_0000);
		queue_request(ACT_LOAD, 2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		queue_request(ACT_TEST, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		queue_request(ACT_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		// back to an all-zero store
		for (int p = 0; p < PLANE_COUNT_DEF; p++)
			queue_request(ACT_LOAD, p, 0, 0, 0, 0);
		queue_request(ACT_TEST, 4, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_ffff);

		// random part: mostly scenes of six planes and small spheres, some noise
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
					if ($urandom_range(0, 5) != 0) begin
						queue_request(ACT_LOAD, p, near_q16(), near_q16(), near_q16(),
							FIELD_WIDTH'($urandom_range(0, 32'h8_0000)));
						n++;
					end
				end
				tests = $urandom_range(10, 30);
				for (int t = 0; t < tests; t++) begin
					queue_request(ACT_TEST, $urandom_range(0, 7), near_q16(), near_q16(),
						near_q16(), ($urandom_range(0, 7) == 0) ? near_q16()
						: FIELD_WIDTH'($urandom_range(0, 32'h10_0000)));
					n++;
				end
			end else begin
				for (int k = $urandom_range(5, 20); k > 0; k--) begin
					queue_request(($urandom_range(0, 2) == 0) ? ACT_LOAD : ACT_TEST,
						$urandom_range(0, 7), wild_q16(), wild_q16(), wild_q16(), wild_q16());
					n++;
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || visible_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sphere_frustum_cull: match");
		else
			$display("sphere_frustum_cull: mismatch");
		$finish;
	end

endmodule
